@@ sv/mwts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mwts_pkg
// Shared types and constants for the moving-window trade signal block:
// configuration register map, reset values and controller/datapath links.
// ----------------------------------------------------------------------------
package mwts_pkg;

    localparam int DEF_MAX_WINDOW = 64;
    localparam int DEF_PRICE_BITS = 24;

    localparam int DAY_BITS      = 16;
    localparam int WL_BITS       = 7;
    localparam int BW_BITS       = 10;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;
    localparam int BAND_FRAC     = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STRATEGY_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_WIDTH_SQ = 2'd2;

    localparam logic MODE_MOMENTUM       = 1'b0;
    localparam logic MODE_MEAN_REVERSION = 1'b1;

    localparam logic [WL_BITS-1:0]  RST_WINDOW_LENGTH = 7'd20;
    localparam logic [BW_BITS-1:0]  RST_BAND_WIDTH_SQ = 10'd36;
    localparam logic [DAY_BITS-1:0] DAY_MAX           = 16'hFFFF;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic mul3;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
        logic out_busy;
    } t_dp_status;

endpackage
`default_nettype wire

@@ sv/mwts_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mwts_ctrl
// Sequencer: accepts one price, steps the datapath through three multiply
// stages and a commit, and holds the commit while a trade record waits.
// ----------------------------------------------------------------------------
module mwts_ctrl
    import mwts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_dp_status i_status,
    output logic            o_in_stall,
    output t_dp_cmd         o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL1   = 3'd1;
    localparam logic [2:0] ST_MUL2   = 3'd2;
    localparam logic [2:0] ST_MUL3   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       commit_ok;

    assign commit_ok  = !(i_status.emit && i_status.out_busy);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        o_cmd        = '0;
        n_state      = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_MUL3;
            end
            ST_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the output register can take the record
                if (commit_ok) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ sv/mwts_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mwts_datapath
// Price ring, running sum and sum of squares, exact crossover and squared
// band tests, open-trade state, configuration registers and output register.
// ----------------------------------------------------------------------------
module mwts_datapath
    import mwts_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int PRICE_BITS = DEF_PRICE_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic [PRICE_BITS-1:0]    i_price,
    input  wire logic                     i_last_day,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_status                    o_status,
    input  wire logic                     i_out_stall,
    output logic                          o_out_valid,
    output logic [DAY_BITS-1:0]           o_entry_day,
    output logic [DAY_BITS-1:0]           o_exit_day,
    output logic [PRICE_BITS-1:0]         o_entry_price,
    output logic [PRICE_BITS-1:0]         o_exit_price,
    output logic                          o_closed_at_end
);

    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NB    = $clog2(MAX_WINDOW + 1);
    localparam int SW    = PRICE_BITS + $clog2(MAX_WINDOW);
    localparam int PPW   = 2 * PRICE_BITS;
    localparam int QW    = PPW + $clog2(MAX_WINDOW);
    localparam int NPW   = NB + PRICE_BITS;
    localparam int SSW   = 2 * SW;
    localparam int NQW   = QW + NB;
    localparam int DSQW  = 2 * SW;
    localparam int RHSW  = NQW + BW_BITS;
    localparam int LHSW  = DSQW + BAND_FRAC;
    localparam int CW    = (RHSW > LHSW) ? RHSW : LHSW;

    // configuration
    logic                  r_mode;
    logic [WL_BITS-1:0]    r_wl;
    logic [BW_BITS-1:0]    r_bw;

    // series state
    logic [PRICE_BITS-1:0] r_ring [MAX_WINDOW];
    logic [SW-1:0]         r_sum;
    logic [QW-1:0]         r_sq;
    logic [AW-1:0]         r_ptr;
    logic [DAY_BITS-1:0]   r_day;
    logic                  r_hold;
    logic [DAY_BITS-1:0]   r_held_day;
    logic [PRICE_BITS-1:0] r_held_price;

    // per-item work registers
    logic [PRICE_BITS-1:0] r_price;
    logic                  r_last;
    logic [PRICE_BITS-1:0] r_old;
    logic [NPW-1:0]        r_np;
    logic [PPW-1:0]        r_pp;
    logic [PPW-1:0]        r_oldsq;
    logic [NQW-1:0]        r_nq;
    logic [SSW-1:0]        r_ss;
    logic                  r_gt;
    logic                  r_lt;
    logic [SW-1:0]         r_diff;
    logic [NQW-1:0]        r_var;
    logic [CW-1:0]         r_lhs;
    logic [CW-1:0]         r_rhs;

    // output register
    logic                  r_out_valid;
    logic [DAY_BITS-1:0]   r_out_entry_day;
    logic [DAY_BITS-1:0]   r_out_exit_day;
    logic [PRICE_BITS-1:0] r_out_entry_price;
    logic [PRICE_BITS-1:0] r_out_exit_price;
    logic                  r_out_end;

    logic [NB-1:0]         n;
    logic [AW-1:0]         slot;
    logic [NB-1:0]         slot_inc;
    logic [AW-1:0]         n_ptr;
    logic                  full;
    logic                  enter;
    logic                  leave;
    logic                  emit;
    logic [SW-1:0]         n_sum;
    logic [QW-1:0]         n_sq;
    logic [DSQW-1:0]       dsq;

    always_comb begin
        if (r_wl == '0) begin
            n = NB'(1);
        end else if (int'(r_wl) > MAX_WINDOW) begin
            n = NB'(MAX_WINDOW);
        end else begin
            n = NB'(r_wl);
        end
    end

    assign slot     = (NB'(r_ptr) < n) ? r_ptr : '0;
    assign slot_inc = NB'(slot) + NB'(1);
    assign n_ptr    = (slot_inc >= n) ? '0 : AW'(slot_inc);
    assign full     = (r_day >= DAY_BITS'(n));

    always_comb begin
        if (r_mode == MODE_MOMENTUM) begin
            enter = r_gt;
            leave = r_lt;
        end else begin
            enter = r_lt && (r_rhs < r_lhs);
            leave = r_gt;
        end
    end

    assign emit  = r_last ? r_hold : (full && r_hold && leave);
    assign n_sum = r_sum - (full ? SW'(r_old) : '0) + SW'(r_price);
    assign n_sq  = r_sq - (full ? QW'(r_oldsq) : '0) + QW'(r_pp);
    assign dsq   = DSQW'(r_diff) * DSQW'(r_diff);

    assign o_status.emit     = emit;
    assign o_status.out_busy = r_out_valid && i_out_stall;

    // ring memory: registered read at accept, write at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_old <= r_ring[slot];
        end
        if (i_cmd.commit && !r_last) begin
            r_ring[slot] <= r_price;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_price <= i_price;
            r_last  <= i_last_day;
        end
        if (i_cmd.mul1) begin
            r_np    <= NPW'(n) * NPW'(r_price);
            r_pp    <= PPW'(r_price) * PPW'(r_price);
            r_oldsq <= PPW'(r_old) * PPW'(r_old);
            r_nq    <= NQW'(n) * NQW'(r_sq);
            r_ss    <= SSW'(r_sum) * SSW'(r_sum);
        end
        if (i_cmd.mul2) begin
            r_gt   <= (r_np > NPW'(r_sum));
            r_lt   <= (r_np < NPW'(r_sum));
            r_diff <= SW'(NPW'(r_sum) - r_np);
            r_var  <= r_nq - NQW'(r_ss);
        end
        if (i_cmd.mul3) begin
            r_lhs <= CW'(dsq) << BAND_FRAC;
            r_rhs <= CW'(r_var) * CW'(r_bw);
        end
        if (i_cmd.commit && !r_last && full && !r_hold && enter) begin
            r_held_day   <= r_day;
            r_held_price <= r_price;
        end
        if (i_cmd.commit && emit) begin
            r_out_entry_day   <= r_held_day;
            r_out_exit_day    <= r_day;
            r_out_entry_price <= r_held_price;
            r_out_exit_price  <= r_price;
            r_out_end         <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_MOMENTUM;
            r_wl        <= RST_WINDOW_LENGTH;
            r_bw        <= RST_BAND_WIDTH_SQ;
            r_sum       <= '0;
            r_sq        <= '0;
            r_ptr       <= '0;
            r_day       <= '0;
            r_hold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.commit) begin
                if (r_last) begin
                    r_sum  <= '0;
                    r_sq   <= '0;
                    r_ptr  <= '0;
                    r_day  <= '0;
                    r_hold <= 1'b0;
                end else begin
                    r_sum <= n_sum;
                    r_sq  <= n_sq;
                    r_ptr <= n_ptr;
                    if (r_day != DAY_MAX) begin
                        r_day <= r_day + DAY_BITS'(1);
                    end
                    if (full && !r_hold && enter) begin
                        r_hold <= 1'b1;
                    end else if (emit) begin
                        r_hold <= 1'b0;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STRATEGY_MODE: begin
                        r_mode <= i_cfg_data[0];
                    end
                    CFG_WINDOW_LENGTH: begin
                        // restart the series under the new window
                        r_wl   <= i_cfg_data[WL_BITS-1:0];
                        r_sum  <= '0;
                        r_sq   <= '0;
                        r_ptr  <= '0;
                        r_day  <= '0;
                        r_hold <= 1'b0;
                    end
                    CFG_BAND_WIDTH_SQ: begin
                        r_bw <= i_cfg_data[BW_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_entry_day     = r_out_entry_day;
    assign o_exit_day      = r_out_exit_day;
    assign o_entry_price   = r_out_entry_price;
    assign o_exit_price    = r_out_exit_price;
    assign o_closed_at_end = r_out_end;

endmodule
`default_nettype wire

@@ sv/moving_window_trade_signal_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// moving_window_trade_signal_top
// Daily price in, trade records out: moving-average crossover or
// squared-form band entry over a sliding window of past prices.
//
//   channel  direction  handshake                    payload
//   in       input      i_in_valid / o_in_stall      i_price, i_last_day
//   out      output     o_out_valid / i_out_stall    o_entry_day, o_exit_day,
//                                                    o_entry_price, o_exit_price,
//                                                    o_closed_at_end
//   cfg      input      i_cfg_we                     i_cfg_index, i_cfg_data
//
// Each price: accept, three multiply stages, commit; the next waits for the commit.
// The sequencer owns a single pass through the datapath multipliers.
// A pending record in the output register stalls only the commit of the next
// record; the output side can stall freely without losing anything.
// Synchronous active-low reset clears control, sums, day count and trade state.
// ----------------------------------------------------------------------------
module moving_window_trade_signal_top
    import mwts_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int PRICE_BITS = DEF_PRICE_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [PRICE_BITS-1:0]    i_price,
    input  wire logic                     i_last_day,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [DAY_BITS-1:0]           o_entry_day,
    output logic [DAY_BITS-1:0]           o_exit_day,
    output logic [PRICE_BITS-1:0]         o_entry_price,
    output logic [PRICE_BITS-1:0]         o_exit_price,
    output logic                          o_closed_at_end
);

    t_dp_cmd    cmd;
    t_dp_status status;

    mwts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    mwts_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_price         (i_price),
        .i_last_day      (i_last_day),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_entry_day     (o_entry_day),
        .o_exit_day      (o_exit_day),
        .o_entry_price   (o_entry_price),
        .o_exit_price    (o_exit_price),
        .o_closed_at_end (o_closed_at_end)
    );

endmodule
`default_nettype wire
